>>> rtl/core/sqn_pkg.sv
// Shared types and constants for the Newton square root block.
package sqn_pkg;

   localparam int COUNT_WIDTH = 9;
   localparam logic [COUNT_WIDTH-1:0] ITER_RESET = COUNT_WIDTH'(300);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_START   = 5'b00010,
      ST_DIVIDE  = 5'b00100,
      ST_UPDATE  = 5'b01000,
      ST_RESPOND = 5'b10000
   } sqn_state_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
   } sqn_cmd_type;

   typedef struct packed {
      logic operand_zero;
      logic div_last;
   } sqn_status_type;

endpackage

>>> rtl/core/sqn_channels.sv
// Channel interfaces: operand request, root response and count register write.
interface sqn_req_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] operand;

   modport source (output valid, output operand, input ready);
   modport sink (input valid, input operand, output ready);
endinterface

interface sqn_rsp_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] root;

   modport source (output valid, output root, input ready);
   modport sink (input valid, input root, output ready);
endinterface

interface sqn_csr_if import sqn_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] iteration_count;

   modport source (output valid, output iteration_count, input ready);
   modport sink (input valid, input iteration_count, output ready);
endinterface

>>> rtl/core/square_root_newton_top.sv
// Top level of the Newton-Raphson fixed-point square root.
//
// req_chan carries an unsigned operand (FRAC_BITS fraction bits); rsp_chan
// returns its root in the same format. csr_chan writes the iteration count
// (reset value 300); it is always ready and should be written only while idle.
// One transaction is in flight at a time: req_chan.ready is high only while
// the block is idle, so the next operand is taken once the root has been taken.
// Each iteration uses one shared restoring divider producing one quotient bit
// per cycle, then updates the estimate. A zero operand or a zero count skips
// the divider and answers with the loaded estimate.
// The result is held in the estimate register with rsp_chan.valid high until
// the receiver raises ready; a stall simply delays the return to idle.
// Synchronous reset returns the controller to idle and the count to 300.
module square_root_newton_top import sqn_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic      clock,
   input logic      reset,
   sqn_req_if.sink  req_chan,
   sqn_rsp_if.source rsp_chan,
   sqn_csr_if.sink  csr_chan
);

   sqn_cmd_type    cmd;
   sqn_status_type status;
   logic           req_ready;
   logic           rsp_valid;
   logic           csr_ready;

   sqn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_chan.iteration_count),
      .cmd       (cmd),
      .status    (status)
   );

   sqn_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .operand (req_chan.operand),
      .root    (rsp_chan.root)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign csr_chan.ready = csr_ready;

   // never take a new transaction while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request accepted while a result is pending");

   // zero operand skips the iterations and answers zero
   a_zero_fast: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.operand == '0)
      |-> ##2 (rsp_chan.valid && rsp_chan.root == '0))
      else $error("zero operand not answered with zero");

   // the divider only runs on a nonzero operand
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> !status.operand_zero)
      else $error("division started on a zero operand");

endmodule

>>> rtl/core/sqn_datapath.sv
// Datapath: operand and estimate registers, radix-2 restoring divider, update.
module sqn_datapath import sqn_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sqn_cmd_type           cmd,
   output sqn_status_type        status,
   input  logic [DATA_WIDTH-1:0] operand,
   output logic [DATA_WIDTH-1:0] root
);

   localparam int QW    = DATA_WIDTH + FRAC_BITS;
   localparam int CNT_W = $clog2(QW);
   localparam logic [QW-1:0] DATA_MAX = QW'({DATA_WIDTH{1'b1}});

   logic [DATA_WIDTH-1:0] operand_ff, operand_in;
   logic [DATA_WIDTH-1:0] estimate_ff, estimate_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;

   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;
   logic [QW-1:0]         q_eff;
   logic [QW:0]           sum;
   logic [QW-1:0]         half;
   logic [DATA_WIDTH-1:0] next_est;

   // one quotient bit per cycle while div_step is set, dividend shifted in from the top of quo_ff
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, estimate_ff};
   assign fits  = trial >= {1'b0, estimate_ff};

   // a zero estimate gives a quotient of DATA_WIDTH ones instead of a division by zero
   assign q_eff    = (estimate_ff == '0) ? DATA_MAX : quo_ff;
   assign sum      = (QW+1)'(estimate_ff) + (QW+1)'(q_eff);
   assign half     = sum[QW:1];
   assign next_est = (half > DATA_MAX) ? {DATA_WIDTH{1'b1}} : half[DATA_WIDTH-1:0];

   always_comb begin
      operand_in  = operand_ff;
      estimate_in = estimate_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      bit_cnt_in  = bit_cnt_ff;
      if (cmd.load) begin
         operand_in  = operand;
         estimate_in = operand;
      end
      if (cmd.div_init) begin
         rem_in     = '0;
         quo_in     = QW'(operand_ff) << FRAC_BITS;
         bit_cnt_in = CNT_W'(QW - 1);
      end
      if (cmd.div_step) begin
         rem_in     = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
         quo_in     = {quo_ff[QW-2:0], fits};
         bit_cnt_in = bit_cnt_ff - CNT_W'(1);
      end
      if (cmd.update) begin
         estimate_in = next_est;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      operand_ff  <= operand_in;
      estimate_ff <= estimate_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
   end

   assign status.operand_zero = (operand_ff == '0);
   assign status.div_last     = (bit_cnt_ff == '0);
   assign root                = estimate_ff;

endmodule

>>> rtl/core/sqn_ctrl.sv
// Controller: sequences load, division, update and response; holds the count register.
module sqn_ctrl import sqn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_WIDTH-1:0] csr_data,
   output sqn_cmd_type            cmd,
   input  sqn_status_type         status
);

   sqn_state_type          state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] steps_ff, steps_in;

   assign csr_ready = 1'b1;
   assign count_in  = csr_valid ? csr_data : count_ff;

   always_comb begin
      state_in  = state_ff;
      steps_in  = steps_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               steps_in = count_ff;
               state_in = ST_START;
            end
         end
         ST_START: begin
            // zero operand or zero count: the loaded estimate is the answer
            if (status.operand_zero || steps_ff == '0) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            steps_in   = steps_ff - COUNT_WIDTH'(1);
            state_in   = (steps_ff == COUNT_WIDTH'(1)) ? ST_RESPOND : ST_START;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= ITER_RESET;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         steps_ff <= steps_in;
      end
   end

endmodule

>>> tb/sqn_root_checker.sv
// Checker for the Newton square root: predicts each root and compares the responses.
`timescale 1ns / 1ps

module sqn_root_checker import sqn_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [DATA_WIDTH-1:0]  req_operand,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [DATA_WIDTH-1:0]  rsp_root,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [COUNT_WIDTH-1:0] csr_iteration_count,
   output int                     error_count,
   output int                     result_backlog
);

   localparam logic [63:0] ROOT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DATA_WIDTH);

   typedef struct packed {
      logic [DATA_WIDTH-1:0] operand;
      logic [DATA_WIDTH-1:0] root;
   } root_expectation_type;

   root_expectation_type   expected_roots[$];
   logic [COUNT_WIDTH-1:0] iteration_count;

   // Newton refinement from x = a; the quotient and the halving both truncate
   function automatic logic [DATA_WIDTH-1:0] newton_root(
      input logic [DATA_WIDTH-1:0]  operand,
      input logic [COUNT_WIDTH-1:0] steps
   );
      logic [63:0] dividend;
      logic [63:0] x;
      logic [63:0] quotient;
      logic [63:0] total;
      dividend = 64'(operand) << FRAC_BITS;
      x = 64'(operand);
      if (operand == '0) begin
         return '0;
      end
      for (int i = 0; i < int'(steps); i++) begin
         quotient = (x == '0) ? ROOT_MAX : dividend / x;
         total = x + quotient;
         if (total < x) begin
            total = '1;
         end
         x = total >> 1;
         if (x > ROOT_MAX) begin
            x = ROOT_MAX;
         end
      end
      return x[DATA_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      root_expectation_type want;
      if (reset) begin
         iteration_count <= ITER_RESET;
         expected_roots.delete();
         error_count <= 0;
         result_backlog <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            iteration_count <= csr_iteration_count;
         end
         // response side first, so a stray result is never matched to this cycle's request
         if (rsp_valid && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected root transaction: expected none, got %h",
                        $time, rsp_root);
               error_count <= error_count + 1;
            end else begin
               want = expected_roots.pop_front();
               if (rsp_root !== want.root) begin
                  $display("%0t: root of operand %h: expected %h, got %h",
                           $time, want.operand, want.root, rsp_root);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            want.operand = req_operand;
            want.root = newton_root(req_operand, iteration_count);
            expected_roots.push_back(want);
         end
         result_backlog <= expected_roots.size();
      end
   end

endmodule

>>> tb/square_root_newton_top_tb.sv
// Testbench top for the Newton square root: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module square_root_newton_top_tb import sqn_pkg::*;;

   localparam int DATA_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int RESET_CYCLES   = 5;
   localparam int IDLE_MAX       = 14;
   localparam int PAUSE_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 100;
   // slowest item: 511 steps plus both sides' longest idling
   localparam int WATCHDOG_LIMIT = 100000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int error_count;
   int result_backlog;
   int operands_sent;
   int count_writes;
   int quiet_cycles;
   bit sender_quiet;

   logic [DATA_WIDTH-1:0] operand_batch[$];

   sqn_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_chan ();
   sqn_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_chan ();
   sqn_csr_if csr_chan ();

   square_root_newton_top #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   sqn_root_checker #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) root_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_chan.valid),
      .req_ready          (req_chan.ready),
      .req_operand        (req_chan.operand),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_root           (rsp_chan.root),
      .csr_valid          (csr_chan.valid),
      .csr_ready          (csr_chan.ready),
      .csr_iteration_count(csr_chan.iteration_count),
      .error_count        (error_count),
      .result_backlog     (result_backlog)
   );

   always #2 clock = ~clock;

   function automatic int idle_draw(input bit quiet);
      return quiet ? 0 : $urandom_range(0, IDLE_MAX);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] random_operand();
      int unsigned k;
      case ($urandom_range(0, 7))
         0: return $urandom_range(1, 32'h0000_FFFF);
         1: begin
            k = $urandom_range(1, 255);
            return DATA_WIDTH'((k * k) << FRAC_BITS);
         end
         2: return $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
         3: return '0;
         default: return $urandom();
      endcase
   endfunction

   task automatic set_count(input logic [COUNT_WIDTH-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.iteration_count <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      count_writes++;
   endtask

   // sends the queued operands, then waits for every root to come back
   task automatic run_batch();
      int gap;
      logic [DATA_WIDTH-1:0] value;
      sender_quiet = ($urandom_range(0, 3) == 0);
      while (operand_batch.size() != 0) begin
         value = operand_batch.pop_front();
         gap = idle_draw(sender_quiet);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_chan.valid <= 1'b1;
         req_chan.operand <= value;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         operands_sent++;
      end
      req_chan.valid <= 1'b0;
      // backlog is registered, so advance the clock before trusting it
      do @(posedge clock); while (result_backlog != 0);
      repeat (PAUSE_CYCLES) @(posedge clock);
   endtask

   initial begin : result_taker
      int stall;
      bit quiet;
      quiet = 1'b0;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            quiet = !quiet;
         end
         stall = idle_draw(quiet);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            @(posedge clock);
            while (!rsp_chan.valid) @(posedge clock);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("square_root_newton_top_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int random_sent;
      int n;
      logic [COUNT_WIDTH-1:0] count;
      req_chan.valid = 1'b0;
      req_chan.operand = '0;
      csr_chan.valid = 1'b0;
      csr_chan.iteration_count = '0;
      operands_sent = 0;
      count_writes = 0;
      random_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count of 300: zero operand, full scale, smallest nonzero
      operand_batch = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
      run_batch();
      // count beyond 300 is taken as written
      set_count(COUNT_WIDTH'(511));
      operand_batch = {32'hFFFF_FFFF, 32'h0001_0000};
      run_batch();
      // zero count hands the operand straight back
      set_count('0);
      operand_batch = {32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000};
      run_batch();
      set_count(COUNT_WIDTH'(1));
      operand_batch = {32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                       32'h0000_0001};
      run_batch();
      set_count(COUNT_WIDTH'(6));
      operand_batch = {32'h0004_0000, 32'h0009_0000, 32'h0000_0100, 32'hFFFF_0000};
      run_batch();

      // random part: mostly short counts to keep the run brief
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: count = COUNT_WIDTH'($urandom_range(17, 40));
            1: count = '0;
            default: count = COUNT_WIDTH'($urandom_range(1, 16));
         endcase
         set_count(count);
         n = $urandom_range(6, 14);
         repeat (n) operand_batch.push_back(random_operand());
         run_batch();
         random_sent += n;
      end

      $display("Checked %0d operands over %0d count writes (0, 1 to 40, 511 and the reset 300),",
               operands_sent, count_writes);
      $display("with random request gaps and response stalls of up to %0d cycles.", IDLE_MAX);
      if (error_count == 0) begin
         $display("square_root_newton_top_tb passed");
      end else begin
         $display("square_root_newton_top_tb failed");
      end
      $finish;
   end

endmodule

>>> square_root_newton_top.f
rtl/core/sqn_pkg.sv
rtl/core/sqn_channels.sv
rtl/core/sqn_datapath.sv
rtl/core/sqn_ctrl.sv
rtl/core/square_root_newton_top.sv
tb/sqn_root_checker.sv
tb/square_root_newton_top_tb.sv
